// ===== design/htnf_pkg.sv =====
// ----------------------------------------------------------------------------
// Handle table package
// Shared types, sizes and codes for the next-fit handle table.
// ----------------------------------------------------------------------------
package htnf_pkg;

    localparam int TABLE_SLOTS = 256;
    localparam int REF_BITS    = 16;
    localparam int IDX_W       = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);
    localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

    typedef enum logic [2:0] {
        ACT_ALLOC   = 3'd0,
        ACT_FREE    = 3'd1,
        ACT_GET     = 3'd2,
        ACT_ADDREF  = 3'd3,
        ACT_RELEASE = 3'd4,
        ACT_CHECK   = 3'd5,
        ACT_COUNT   = 3'd6,
        ACT_DUP     = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BADH = 2'd2,
        ST_NULL = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_DUPRD,
        S_WRITE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] slot_index;
        logic [31:0] segment_tag;
        logic [31:0] owner_id;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  handle_out;
        logic [31:0] segment_out;
        logic        is_valid;
        logic [8:0]  match_count;
        logic [8:0]  in_use_total;
        logic [8:0]  free_total;
        logic        segment_ref_bump;
    } t_out;

endpackage

// ===== design/htnf_store.sv =====
// ----------------------------------------------------------------------------
// Handle table slot store
// Valid bits in flip-flops; segment and count in registered-read memories.
// ----------------------------------------------------------------------------
module htnf_store (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [htnf_pkg::IDX_W-1:0] i_raddr,
    output logic                       o_rvalid,
    output logic [31:0]                o_rseg,
    output logic [htnf_pkg::REF_BITS-1:0] o_rrefs,
    input  logic                       i_we,
    input  logic [htnf_pkg::IDX_W-1:0] i_waddr,
    input  logic                       i_wvalid,
    input  logic [31:0]                i_wseg,
    input  logic [htnf_pkg::REF_BITS-1:0] i_wrefs
);
    import htnf_pkg::*;

    logic [TABLE_SLOTS-1:0]        r_valid;
    logic [31:0]                   r_seg_mem  [TABLE_SLOTS];
    logic [REF_BITS-1:0]           r_refs_mem [TABLE_SLOTS];
    logic                          r_rvalid;
    logic [31:0]                   r_rseg;
    logic [REF_BITS-1:0]           r_rrefs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) r_valid[i_waddr] <= i_wvalid;
            r_rvalid <= r_valid[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_seg_mem[i_waddr]  <= i_wseg;
            r_refs_mem[i_waddr] <= i_wrefs;
        end
        r_rseg  <= r_seg_mem[i_raddr];
        r_rrefs <= r_refs_mem[i_raddr];
    end

    assign o_rvalid = r_rvalid;
    assign o_rseg   = r_rseg;
    assign o_rrefs  = r_rrefs;
endmodule

// ===== design/handle_table_next_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// Next-fit handle table allocator
// Slot table with next-fit allocation, reference counts and tag counting.
// ----------------------------------------------------------------------------
//  channel | signals                         | direction
//  in      | i_in_valid, o_in_stall, i_in    | request transaction
//  out     | o_out_valid, i_out_stall, o_out | result transaction
//
// Single-slot actions go from accept through S_LOOK and S_DUPRD to the result in S_DONE.
// Alloc, dup and count walk the table one slot a cycle through the store's
// single read port, looking at each slot at most once (dup reads its source slot first).
// Reset clears the valid bits at once; no clearing pass is needed.
// The input is stalled from accept until the result transaction completes.
module handle_table_next_fit_allocator (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  htnf_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output htnf_pkg::t_out  o_out
);
    import htnf_pkg::*;

    t_state               r_state, n_state;
    t_in                  r_req;
    t_out                 r_out, n_out;
    logic [CNT_W-1:0]     r_used, n_used;
    logic [IDX_W-1:0]     r_cursor, n_cursor;
    logic [IDX_W-1:0]     r_addr, n_addr;
    logic [CNT_W-1:0]     r_steps, n_steps;
    logic [CNT_W-1:0]     r_match, n_match;
    logic [31:0]          r_seg, n_seg;

    logic                 s_rvalid;
    logic [31:0]          s_rseg;
    logic [REF_BITS-1:0]  s_rrefs;
    logic [IDX_W-1:0]     s_raddr;
    logic                 s_we, s_wvalid;
    logic [IDX_W-1:0]     s_waddr;
    logic [31:0]          s_wseg;
    logic [REF_BITS-1:0]  s_wrefs;

    logic                 inrange;
    logic [IDX_W-1:0]     req_idx;
    logic [IDX_W-1:0]     addr_inc;

    assign inrange  = r_req.slot_index < 16'(TABLE_SLOTS);
    assign req_idx  = r_req.slot_index[IDX_W-1:0];
    assign addr_inc = r_addr + IDX_W'(1);

    htnf_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_raddr (s_raddr),
        .o_rvalid(s_rvalid),
        .o_rseg  (s_rseg),
        .o_rrefs (s_rrefs),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wvalid(s_wvalid),
        .i_wseg  (s_wseg),
        .i_wrefs (s_wrefs)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_cursor <= '0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_cursor <= n_cursor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) r_req <= i_in;
        r_out   <= n_out;
        r_addr  <= n_addr;
        r_steps <= n_steps;
        r_match <= n_match;
        r_seg   <= n_seg;
    end

    // The store read address walks one step ahead of the registered data,
    // so in S_SCAN the data on s_r* belongs to the slot before r_addr.
    always_comb begin
        n_state  = r_state;
        n_out    = r_out;
        n_used   = r_used;
        n_cursor = r_cursor;
        n_addr   = r_addr;
        n_steps  = r_steps;
        n_match  = r_match;
        n_seg    = r_seg;
        s_raddr  = r_addr;
        s_we     = 1'b0;
        s_waddr  = r_addr;
        s_wvalid = 1'b0;
        s_wseg   = '0;
        s_wrefs  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_LOOK;
            end
            S_LOOK: begin
                n_out = '0;
                n_match = '0;
                n_steps = '0;
                n_seg = r_req.segment_tag;
                case (t_action'(r_req.action))
                    ACT_ALLOC, ACT_COUNT: begin
                        n_addr = (r_req.action == ACT_ALLOC) ? r_cursor : '0;
                        s_raddr = n_addr;
                        if (r_req.segment_tag == '0) begin
                            n_out.status = ST_NULL;
                            n_state = S_DONE;
                        end else begin
                            n_addr = n_addr + IDX_W'(1);
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                        n_addr = req_idx;
                        s_raddr = req_idx;
                        n_state = S_DUPRD;
                    end
                endcase
            end
            S_DUPRD: begin
                // Store data for the requested slot is available here.
                n_state = S_DONE;
                if (!inrange) begin
                    n_out.status = ST_BADH;
                end else begin
                    case (t_action'(r_req.action))
                        ACT_CHECK: n_out.is_valid = s_rvalid;
                        ACT_FREE: begin
                            if (!s_rvalid) n_out.status = ST_BADH;
                            else begin
                                s_we = 1'b1;
                                n_used = r_used - CNT_W'(1);
                            end
                        end
                        ACT_GET: begin
                            if (!s_rvalid) n_out.status = ST_BADH;
                            else begin
                                n_out.segment_out = s_rseg;
                                n_out.is_valid = 1'b1;
                            end
                        end
                        ACT_ADDREF, ACT_RELEASE: begin
                            if (!s_rvalid) n_out.status = ST_BADH;
                            else begin
                                s_we = 1'b1;
                                s_wvalid = 1'b1;
                                s_wseg = s_rseg;
                                s_wrefs = s_rrefs;
                                if (r_req.action == ACT_ADDREF) begin
                                    if (s_rrefs != REF_MAX) s_wrefs = s_rrefs + 1'b1;
                                end else if (s_rrefs != '0) begin
                                    s_wrefs = s_rrefs - 1'b1;
                                end
                            end
                        end
                        ACT_DUP: begin
                            if (!s_rvalid) n_out.status = ST_BADH;
                            else if (s_rseg == '0) n_out.status = ST_NULL;
                            else begin
                                n_seg = s_rseg;
                                n_addr = r_cursor + IDX_W'(1);
                                s_raddr = r_cursor;
                                n_state = S_SCAN;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                n_steps = r_steps + CNT_W'(1);
                n_addr = addr_inc;
                if (r_req.action == ACT_COUNT) begin
                    if (s_rvalid && s_rseg == r_seg) n_match = r_match + CNT_W'(1);
                    if (r_steps == CNT_W'(TABLE_SLOTS - 1)) begin
                        n_out.match_count = 9'(n_match);
                        n_state = S_DONE;
                    end
                end else if (!s_rvalid) begin
                    n_addr = r_addr - IDX_W'(1);
                    n_state = S_WRITE;
                end else if (r_steps == CNT_W'(TABLE_SLOTS - 1)) begin
                    n_out.status = ST_FULL;
                    n_state = S_DONE;
                end
            end
            S_WRITE: begin
                s_we = 1'b1;
                s_wvalid = 1'b1;
                s_wseg = r_seg;
                s_wrefs = REF_BITS'(1);
                n_used = r_used + CNT_W'(1);
                n_cursor = addr_inc;
                n_out.handle_out = 8'(r_addr);
                n_out.segment_ref_bump = (r_req.action == ACT_DUP);
                n_state = S_DONE;
            end
            S_DONE: begin
                n_out.in_use_total = 9'(r_used);
                n_out.free_total = 9'(CNT_W'(TABLE_SLOTS) - r_used);
                if (!i_out_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_DONE);
    always_comb begin
        o_out = r_out;
        o_out.in_use_total = 9'(r_used);
        o_out.free_total = 9'(CNT_W'(TABLE_SLOTS) - r_used);
    end

`ifndef SYNTHESIS
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(TABLE_SLOTS))
        else $error("used count exceeds table size");
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while result pending");
    a_cursor_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_WRITE) |=> $stable(r_cursor))
        else $error("cursor moved without allocation");
    a_used_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE || r_state == S_IDLE) |=> $stable(r_used))
        else $error("used count changed outside an action");
`endif
endmodule

// ===== verif/htnf_checker.sv =====
// ----------------------------------------------------------------------------
// Handle table result checker
// Watches both channels, keeps a model of the slot table, predicts each
// result and compares it field by field with the block's output.
// ----------------------------------------------------------------------------
module htnf_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_stall,
    input  htnf_pkg::t_in   i_in,
    input  logic            i_out_valid,
    input  logic            i_out_stall,
    input  htnf_pkg::t_out  i_out,
    output int              o_fail_count,
    output int              o_pending
);
    import htnf_pkg::*;

    logic                tbl_live  [TABLE_SLOTS];
    logic [31:0]         tbl_seg   [TABLE_SLOTS];
    logic [REF_BITS-1:0] tbl_refs  [TABLE_SLOTS];
    int                  live_total;
    int                  cursor;
    t_out                expected_results[$];

    assign o_pending = expected_results.size();

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        o_fail_count++;
    endtask

    // Next-fit search; returns the slot or -1 when the table is full.
    function automatic int take_slot(input logic [31:0] seg);
        int h;
        h = cursor;
        for (int n = 0; n < TABLE_SLOTS; n++) begin
            if (!tbl_live[h]) begin
                tbl_live[h] = 1'b1;
                tbl_seg[h]  = seg;
                tbl_refs[h] = REF_BITS'(1);
                live_total++;
                cursor = (h + 1) % TABLE_SLOTS;
                return h;
            end
            h = (h + 1) % TABLE_SLOTS;
        end
        return -1;
    endfunction

    function automatic t_out predict_result(input t_in req);
        t_out r;
        logic inrange, live;
        logic [IDX_W-1:0] idx;
        int s, m;
        r = '0;
        r.status = ST_OK;
        idx = req.slot_index[IDX_W-1:0];
        inrange = req.slot_index < TABLE_SLOTS;
        live = inrange && tbl_live[idx];
        case (t_action'(req.action))
            ACT_ALLOC: begin
                if (req.segment_tag == 0) r.status = ST_NULL;
                else begin
                    s = take_slot(req.segment_tag);
                    if (s < 0) r.status = ST_FULL;
                    else r.handle_out = s[7:0];
                end
            end
            ACT_FREE: begin
                if (!live) r.status = ST_BADH;
                else begin
                    tbl_live[idx] = 1'b0;
                    tbl_seg[idx]  = '0;
                    tbl_refs[idx] = '0;
                    live_total--;
                end
            end
            ACT_GET: begin
                if (!live) r.status = ST_BADH;
                else begin
                    r.segment_out = tbl_seg[idx];
                    r.is_valid = 1'b1;
                end
            end
            ACT_ADDREF: begin
                if (!live) r.status = ST_BADH;
                else if (tbl_refs[idx] != REF_MAX)
                    tbl_refs[idx]++;
            end
            ACT_RELEASE: begin
                if (!live) r.status = ST_BADH;
                else if (tbl_refs[idx] != 0)
                    tbl_refs[idx]--;
            end
            ACT_CHECK: begin
                if (!inrange) r.status = ST_BADH;
                else r.is_valid = live;
            end
            ACT_COUNT: begin
                if (req.segment_tag == 0) r.status = ST_NULL;
                else begin
                    m = 0;
                    for (int i = 0; i < TABLE_SLOTS; i++)
                        if (tbl_live[i] && tbl_seg[i] == req.segment_tag) m++;
                    r.match_count = m[8:0];
                end
            end
            default: begin
                if (!live) r.status = ST_BADH;
                else if (tbl_seg[idx] == 0) r.status = ST_NULL;
                else begin
                    s = take_slot(tbl_seg[idx]);
                    if (s < 0) r.status = ST_FULL;
                    else begin
                        r.handle_out = s[7:0];
                        r.segment_ref_bump = 1'b1;
                    end
                end
            end
        endcase
        r.in_use_total = live_total[8:0];
        r.free_total   = 9'(TABLE_SLOTS - live_total);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                tbl_live[i] = 1'b0;
                tbl_seg[i]  = '0;
                tbl_refs[i] = '0;
            end
            live_total = 0;
            cursor = 0;
            o_fail_count = 0;
            expected_results.delete();
        end else begin
            // Output side first: a result never belongs to the request
            // accepted at the same edge.
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result transaction", 32'd1, 32'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_out.status != want.status)
                        report_mismatch("status", i_out.status, want.status);
                    if (i_out.handle_out != want.handle_out)
                        report_mismatch("handle_out", i_out.handle_out,
                                        want.handle_out);
                    if (i_out.segment_out != want.segment_out)
                        report_mismatch("segment_out", i_out.segment_out,
                                        want.segment_out);
                    if (i_out.is_valid != want.is_valid)
                        report_mismatch("is_valid", i_out.is_valid, want.is_valid);
                    if (i_out.match_count != want.match_count)
                        report_mismatch("match_count", i_out.match_count,
                                        want.match_count);
                    if (i_out.in_use_total != want.in_use_total)
                        report_mismatch("in_use_total", i_out.in_use_total,
                                        want.in_use_total);
                    if (i_out.free_total != want.free_total)
                        report_mismatch("free_total", i_out.free_total,
                                        want.free_total);
                    if (i_out.segment_ref_bump != want.segment_ref_bump)
                        report_mismatch("segment_ref_bump", i_out.segment_ref_bump,
                                        want.segment_ref_bump);
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(predict_result(i_in));
        end
    end
endmodule

// ===== verif/tb_handle_table_next_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// Handle table testbench
// Drives directed and random handle requests with idling and stalls on
// both channels; the checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb_handle_table_next_fit_allocator;
    import htnf_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic   i_clk;
    logic   i_rst_n;
    logic   in_valid;
    logic   in_stall;
    t_in    in_req;
    logic   out_valid;
    logic   out_stall;
    t_out   out_res;
    int     fail_count;
    int     pending;
    int     idle_pct;
    int     stall_pct;
    logic   hold_off;
    int     idle_cycles;
    logic [31:0] tag_pool[4];

    handle_table_next_fit_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in(in_req),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out(out_res)
    );

    htnf_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in(in_req),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out(out_res),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver stall, random per cycle unless a long hold-off is on.
    always @(posedge i_clk) begin
        if (!i_rst_n) out_stall <= 1'b0;
        else if (hold_off) out_stall <= 1'b1;
        else out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offers one request and waits until it is accepted. Valid stays high
    // after the accept; the next request or an idle cycle replaces it.
    task automatic send_request(input t_action act, input logic [15:0] idx,
                                input logic [31:0] seg, input logic [31:0] owner);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_req <= '{action: act, slot_index: idx, segment_tag: seg, owner_id: owner};
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    task automatic send_random;
        t_action act;
        logic [15:0] idx;
        logic [31:0] seg;
        int r;
        act = t_action'($urandom_range(7));
        r = $urandom_range(99);
        if (r < 85) idx = 16'($urandom_range(TABLE_SLOTS - 1));
        else idx = 16'($urandom);
        r = $urandom_range(99);
        if (r < 60) seg = tag_pool[$urandom_range(3)];
        else if (r < 65) seg = '0;
        else seg = $urandom;
        // Bias toward alloc so the table holds live slots.
        if ($urandom_range(99) < 20) act = ACT_ALLOC;
        send_request(act, idx, seg, $urandom);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_req = '0;
        hold_off = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        tag_pool = '{32'h1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_BEEF};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: null tags, bad handles, extremes and every action.
        send_request(ACT_ALLOC, 16'd0, 32'd0, 32'd0);
        send_request(ACT_COUNT, 16'd0, 32'd0, 32'd0);
        send_request(ACT_ALLOC, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(ACT_ALLOC, 16'd0, 32'h1, 32'h0);
        send_request(ACT_GET, 16'd0, 32'd0, 32'd0);
        send_request(ACT_GET, 16'd255, 32'd0, 32'd0);
        send_request(ACT_GET, 16'd256, 32'd0, 32'd0);
        send_request(ACT_CHECK, 16'hFFFF, 32'd0, 32'd0);
        send_request(ACT_CHECK, 16'd5, 32'd0, 32'd0);
        send_request(ACT_CHECK, 16'd1, 32'd0, 32'd0);
        send_request(ACT_ADDREF, 16'd0, 32'd0, 32'd0);
        send_request(ACT_RELEASE, 16'd0, 32'd0, 32'd0);
        send_request(ACT_RELEASE, 16'd0, 32'd0, 32'd0);
        send_request(ACT_RELEASE, 16'd0, 32'd0, 32'd0);
        send_request(ACT_ADDREF, 16'd9, 32'd0, 32'd0);
        send_request(ACT_DUP, 16'd0, 32'd0, 32'h1234_5678);
        send_request(ACT_DUP, 16'd200, 32'd0, 32'd0);
        send_request(ACT_DUP, 16'hFFFF, 32'd0, 32'd0);
        send_request(ACT_COUNT, 16'd0, 32'hFFFF_FFFF, 32'd0);
        send_request(ACT_FREE, 16'd1, 32'd0, 32'd0);
        send_request(ACT_FREE, 16'd1, 32'd0, 32'd0);
        send_request(ACT_FREE, 16'd300, 32'd0, 32'd0);
        drain();

        // Fill the table to reach the full case; the receiver holds off for a
        // long stretch meanwhile, so the input backs up.
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < TABLE_SLOTS + 2; i++)
                send_request(ACT_ALLOC, 16'd0, tag_pool[i % 4], $urandom);
        join
        send_request(ACT_DUP, 16'd3, 32'd0, 32'd0);
        send_request(ACT_COUNT, 16'd0, tag_pool[0], 32'd0);
        // Saturate one slot's count the quick way is too slow; push a few.
        for (int i = 0; i < 4; i++) send_request(ACT_ADDREF, 16'd7, 32'd0, 32'd0);
        for (int i = 0; i < 60; i++)
            send_request(ACT_FREE, 16'($urandom_range(255)), 32'd0, 32'd0);
        // Sender pause until every expected result has come.
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 62; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 62; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            for (int i = 0; i < 40; i++) send_random();
        end

        drain();
        repeat (TABLE_SLOTS + 10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
